>>> rtl/sbva_pkg.sv
// ----------------------------------------------------------------------------
// sbva_pkg: shared types and helpers for the sized bit vector ALU
// Beat structs for both channels, the internal stage structs, the opcode
// enum and the mask and sign-extension helpers.
// ----------------------------------------------------------------------------
package sbva_pkg;

    localparam int unsigned DataW = 64;
    localparam int unsigned LenW  = 7;

    typedef enum logic [4:0] {
        KIND_GETBIT = 5'd0,
        KIND_SLICE  = 5'd1,
        KIND_SEXT   = 5'd2,
        KIND_ZEXT   = 5'd3,
        KIND_NOT    = 5'd4,
        KIND_AND    = 5'd5,
        KIND_OR     = 5'd6,
        KIND_XOR    = 5'd7,
        KIND_ADD    = 5'd8,
        KIND_NEG    = 5'd9,
        KIND_SUB    = 5'd10,
        KIND_CAT    = 5'd11,
        KIND_SRL    = 5'd12,
        KIND_SRA    = 5'd13,
        KIND_SLL    = 5'd14,
        KIND_LT     = 5'd15,
        KIND_EQ     = 5'd16,
        KIND_LTU    = 5'd17,
        KIND_IMM_B  = 5'd18,
        KIND_IMM_J  = 5'd19,
        KIND_IMM_S  = 5'd20
    } t_kind;

    typedef struct packed {
        logic [4:0]       kind;
        logic [LenW-1:0]  len_a;
        logic [DataW-1:0] val_a;
        logic [LenW-1:0]  len_b;
        logic [DataW-1:0] val_b;
        logic [5:0]       bit_low;
        logic [LenW-1:0]  bit_high;
    } t_alu_in;

    typedef struct packed {
        logic [DataW-1:0] result_val;
        logic [LenW-1:0]  result_len;
    } t_alu_out;

    // decode -> prepare
    typedef struct packed {
        t_kind            kind;
        logic [LenW-1:0]  la;
        logic [LenW-1:0]  lb;
        logic [LenW-1:0]  m;
        logic [5:0]       lo;
        logic [LenW-1:0]  hi;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic [DataW-1:0] am;
        logic [DataW-1:0] bm;
        logic [DataW-1:0] nbm;
        logic [5:0]       sh;
    } t_dec;

    // prepare -> execute
    typedef struct packed {
        t_kind            kind;
        logic [LenW-1:0]  la;
        logic [LenW-1:0]  lb;
        logic [LenW-1:0]  m;
        logic [5:0]       lo;
        logic [LenW-1:0]  hi;
        logic [DataW-1:0] a;
        logic [DataW-1:0] am;
        logic [DataW-1:0] bm;
        logic [5:0]       sh;
        logic [DataW-1:0] sa;
        logic [DataW-1:0] sb;
        logic [DataW-1:0] add_x;
        logic [DataW-1:0] add_y;
    } t_prep;

    // low n bits set, n from 0 to 64
    function automatic logic [DataW-1:0] lowmask(input logic [LenW-1:0] n);
        lowmask = (n >= LenW'(DataW)) ? {DataW{1'b1}} : ~({DataW{1'b1}} << n[5:0]);
    endfunction

    // sign-extend the low n bits (1 to 64) of v
    function automatic logic [DataW-1:0] sext(input logic [LenW-1:0] n,
                                              input logic [DataW-1:0] v);
        logic [5:0]       idx;
        logic [DataW-1:0] msk;
        idx  = 6'(n - LenW'(1));
        msk  = lowmask(n);
        sext = (v & msk) | (v[idx] ? ~msk : '0);
    endfunction

endpackage

>>> rtl/sbva_decode.sv
// ----------------------------------------------------------------------------
// sbva_decode: first pipeline stage
// Clamps lengths and slice bound, masks operands, forms the shift amount
// and the two's-complement of operand b.
// ----------------------------------------------------------------------------
module sbva_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  sbva_pkg::t_alu_in i_data,
    input  logic             i_stall,
    output logic             o_valid,
    output sbva_pkg::t_dec   o_data,
    output logic             o_stall
);
    import sbva_pkg::*;

    logic   r_valid;
    t_dec   r_data;
    t_dec   n_data;
    logic   load;

    function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] l);
        if (l == '0) begin
            clamp_len = LenW'(1);
        end else if (l > LenW'(DataW)) begin
            clamp_len = LenW'(DataW);
        end else begin
            clamp_len = l;
        end
    endfunction

    assign o_stall = r_valid && i_stall;
    assign load    = !o_stall;

    always_comb begin
        n_data      = '0;
        n_data.kind = t_kind'(i_data.kind);
        n_data.la   = clamp_len(i_data.len_a);
        n_data.lb   = clamp_len(i_data.len_b);
        n_data.m    = (n_data.la > n_data.lb) ? n_data.la : n_data.lb;
        n_data.lo   = i_data.bit_low;
        n_data.hi   = (i_data.bit_high > LenW'(DataW)) ? LenW'(DataW) : i_data.bit_high;
        n_data.a    = i_data.val_a;
        n_data.b    = i_data.val_b;
        n_data.am   = i_data.val_a & lowmask(n_data.la);
        n_data.bm   = i_data.val_b & lowmask(n_data.lb);
        n_data.nbm  = (~i_data.val_b + DataW'(1)) & lowmask(n_data.lb);
        n_data.sh   = n_data.bm[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/sbva_prep.sv
// ----------------------------------------------------------------------------
// sbva_prep: second pipeline stage
// Sign-extends both operands and sets up the shared adder inputs for
// add, sub and negate.
// ----------------------------------------------------------------------------
module sbva_prep (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  sbva_pkg::t_dec i_data,
    input  logic           i_stall,
    output logic           o_valid,
    output sbva_pkg::t_prep o_data,
    output logic           o_stall
);
    import sbva_pkg::*;

    logic             r_valid;
    t_prep            r_data;
    t_prep            n_data;
    logic             load;
    logic [DataW-1:0] mmask;
    logic [DataW-1:0] y_src;

    assign o_stall = r_valid && i_stall;
    assign load    = !o_stall;

    always_comb begin
        mmask       = lowmask(i_data.m);
        y_src       = (i_data.kind == KIND_SUB) ? i_data.nbm : i_data.b;
        n_data.kind = i_data.kind;
        n_data.la   = i_data.la;
        n_data.lb   = i_data.lb;
        n_data.m    = i_data.m;
        n_data.lo   = i_data.lo;
        n_data.hi   = i_data.hi;
        n_data.a    = i_data.a;
        n_data.am   = i_data.am;
        n_data.bm   = i_data.bm;
        n_data.sh   = i_data.sh;
        n_data.sa   = sext(i_data.la, i_data.a);
        n_data.sb   = sext(i_data.lb, i_data.b);
        // negate runs through the adder as ~a + 1
        if (i_data.kind == KIND_NEG) begin
            n_data.add_x = ~i_data.a;
            n_data.add_y = DataW'(1);
        end else begin
            n_data.add_x = n_data.sa & mmask;
            n_data.add_y = sext(i_data.lb, y_src) & mmask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/sbva_exec.sv
// ----------------------------------------------------------------------------
// sbva_exec: third pipeline stage
// Adder, shifters, compares, immediate extraction and the opcode mux.
// Produces the raw result bits and the result length.
// ----------------------------------------------------------------------------
module sbva_exec (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sbva_pkg::t_prep   i_data,
    input  logic              i_stall,
    output logic              o_valid,
    output sbva_pkg::t_alu_out o_data,
    output logic              o_stall
);
    import sbva_pkg::*;

    logic             r_valid;
    t_alu_out         r_data;
    t_alu_out         n_data;
    logic             load;
    logic [DataW-1:0] sum;
    logic [7:0]       cat_sum;
    logic [LenW-1:0]  cat_len;
    logic [DataW-1:0] cat_hi;
    logic [LenW-1:0]  add_len;
    logic [DataW-1:0] a;

    assign o_stall = r_valid && i_stall;
    assign load    = !o_stall;

    always_comb begin
        a       = i_data.a;
        sum     = i_data.add_x + i_data.add_y;
        add_len = (i_data.m == LenW'(DataW)) ? LenW'(DataW) : i_data.m + LenW'(1);
        cat_sum = 8'(i_data.la) + 8'(i_data.lb);
        cat_len = (cat_sum > 8'(DataW)) ? LenW'(DataW) : cat_sum[LenW-1:0];
        // a sits above b; drop its top bits that do not fit
        cat_hi  = i_data.lb[6] ? '0 :
                  ((a & lowmask(cat_len - i_data.lb)) << i_data.lb[5:0]);
        n_data  = '0;
        unique case (i_data.kind)
            KIND_GETBIT: begin
                n_data.result_val = DataW'(i_data.am[i_data.lo]);
                n_data.result_len = LenW'(1);
            end
            KIND_SLICE: begin
                if (i_data.hi > LenW'(i_data.lo)) begin
                    n_data.result_val = i_data.am >> i_data.lo;
                    n_data.result_len = i_data.hi - LenW'(i_data.lo);
                end
            end
            KIND_SEXT: begin
                n_data.result_val = i_data.sa;
                n_data.result_len = LenW'(DataW);
            end
            KIND_ZEXT: begin
                n_data.result_val = i_data.am;
                n_data.result_len = LenW'(DataW);
            end
            KIND_NOT: begin
                n_data.result_val = ~a;
                n_data.result_len = i_data.la;
            end
            KIND_AND: begin
                n_data.result_val = i_data.sa & i_data.sb;
                n_data.result_len = i_data.m;
            end
            KIND_OR: begin
                n_data.result_val = i_data.sa | i_data.sb;
                n_data.result_len = i_data.m;
            end
            KIND_XOR: begin
                n_data.result_val = i_data.sa ^ i_data.sb;
                n_data.result_len = i_data.m;
            end
            KIND_ADD, KIND_SUB: begin
                n_data.result_val = sum;
                n_data.result_len = add_len;
            end
            KIND_NEG: begin
                n_data.result_val = sum;
                n_data.result_len = i_data.la;
            end
            KIND_CAT: begin
                n_data.result_val = cat_hi | i_data.bm;
                n_data.result_len = cat_len;
            end
            KIND_SRL: begin
                n_data.result_val = i_data.am >> i_data.sh;
                n_data.result_len = i_data.la;
            end
            KIND_SRA: begin
                n_data.result_val = unsigned'($signed(i_data.sa) >>> i_data.sh);
                n_data.result_len = i_data.la;
            end
            KIND_SLL: begin
                n_data.result_val = a << i_data.sh;
                n_data.result_len = i_data.la;
            end
            KIND_LT: begin
                n_data.result_val = DataW'($signed(i_data.sa) < $signed(i_data.sb));
                n_data.result_len = LenW'(1);
            end
            KIND_EQ: begin
                n_data.result_val = DataW'(i_data.sa == i_data.sb);
                n_data.result_len = LenW'(1);
            end
            KIND_LTU: begin
                n_data.result_val = DataW'(i_data.am < i_data.bm);
                n_data.result_len = LenW'(1);
            end
            KIND_IMM_B: begin
                n_data.result_val = {32'd0, {19{a[31]}}, a[31], a[7], a[30:25],
                                     a[11:8], 1'b0};
                n_data.result_len = LenW'(32);
            end
            KIND_IMM_J: begin
                n_data.result_val = {32'd0, {11{a[31]}}, a[31], a[19:12], a[20],
                                     a[30:21], 1'b0};
                n_data.result_len = LenW'(32);
            end
            KIND_IMM_S: begin
                n_data.result_val = {32'd0, {20{a[31]}}, a[31:25], a[11:7]};
                n_data.result_len = LenW'(32);
            end
            default: begin
                n_data = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/sbva_out.sv
// ----------------------------------------------------------------------------
// sbva_out: output stage
// Masks the raw result to its length and holds the beat for the receiver.
// ----------------------------------------------------------------------------
module sbva_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sbva_pkg::t_alu_out i_data,
    input  logic               i_stall,
    output logic               o_valid,
    output sbva_pkg::t_alu_out o_data,
    output logic               o_stall
);
    import sbva_pkg::*;

    logic     r_valid;
    t_alu_out r_data;
    t_alu_out n_data;
    logic     load;

    assign o_stall = r_valid && i_stall;
    assign load    = !o_stall;

    always_comb begin
        n_data.result_val = i_data.result_val & lowmask(i_data.result_len);
        n_data.result_len = i_data.result_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/sized_bit_vector_alu.sv
// ----------------------------------------------------------------------------
// sized_bit_vector_alu: ALU on sized bit vectors of 1 to 64 bits
// Channel   | Direction | Handshake                   | Beat
// in        | input     | i_in_valid / o_in_stall     | i_in_data  (t_alu_in)
// out       | output    | o_out_valid / i_out_stall   | o_out_data (t_alu_out)
//
// One beat per cycle enters and leaves while i_out_stall is low; each beat
// passes through the decode, prepare, execute and output register stages.
// The execute stage (64-bit adder, shifters, compares) sets the clock.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stall holds only the full stages ahead of it; bubbles still advance.
// ----------------------------------------------------------------------------
module sized_bit_vector_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  sbva_pkg::t_alu_in  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output sbva_pkg::t_alu_out o_out_data,
    input  logic               i_out_stall
);
    import sbva_pkg::*;

    logic     dec_valid;
    t_dec     dec_data;
    logic     dec_stall;
    logic     prep_valid;
    t_prep    prep_data;
    logic     prep_stall;
    logic     exec_valid;
    t_alu_out exec_data;
    logic     exec_stall;

    sbva_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_stall (prep_stall),
        .o_valid (dec_valid),
        .o_data  (dec_data),
        .o_stall (o_in_stall)
    );

    sbva_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .i_data  (dec_data),
        .i_stall (exec_stall),
        .o_valid (prep_valid),
        .o_data  (prep_data),
        .o_stall (prep_stall)
    );

    sbva_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_valid),
        .i_data  (prep_data),
        .i_stall (dec_stall),
        .o_valid (exec_valid),
        .o_data  (exec_data),
        .o_stall (exec_stall)
    );

    sbva_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (exec_valid),
        .i_data  (exec_data),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_stall (dec_stall)
    );

    // a stall reaches the input only when every stage holds a beat
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && exec_valid && prep_valid
                        && dec_valid))
        else $error("input stalled while a stage is empty");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.result_len <= LenW'(DataW)))
        else $error("result length above 64");

    a_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_data.result_val & ~lowmask(o_out_data.result_len)) == '0))
        else $error("result bits set above result length");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> dec_valid)
        else $error("accepted beat missing from decode stage");

endmodule
